// File: src/rpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types and constants of the RGB PWM fade controller.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int NUM_CH = 3;

  localparam logic [5:0] LAST_SLOT = 6'd63;
  localparam logic [7:0] FPS_RESET = 8'd1;

  typedef logic [7:0] level_t;
  typedef logic [5:0] slot_t;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_FADE = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef struct packed {
    req_e   req_type;
    level_t red;
    level_t green;
    level_t blue;
  } req_t;

  typedef struct packed {
    logic   red_on;
    logic   green_on;
    logic   blue_on;
    logic   fading_now;
    level_t level_red;
    level_t level_green;
    level_t level_blue;
  } result_t;

endpackage

// File: src/rpf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_ifs
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface rpf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, req_type, red, green, blue, input ready);
  modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface rpf_res_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic       fading_now;
  logic [7:0] level_red;
  logic [7:0] level_green;
  logic [7:0] level_blue;

  modport source (output valid, red_on, green_on, blue_on, fading_now,
                  level_red, level_green, level_blue, input ready);
  modport sink   (input valid, red_on, green_on, blue_on, fading_now,
                  level_red, level_green, level_blue, output ready);
endinterface

// File: src/rpf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_core
// PWM slot counter, fade engine and channel drive state; one beat per step.
// ----------------------------------------------------------------------------
module rpf_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rpf_pkg::req_t    item,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  output rpf_pkg::result_t result
);

  logic [7:0]                              frames_per_step;
  rpf_pkg::slot_t                          pwm_tick;
  rpf_pkg::level_t [rpf_pkg::NUM_CH-1:0]   levels;
  rpf_pkg::level_t [rpf_pkg::NUM_CH-1:0]   targets;
  logic                                    fading;
  logic [7:0]                              frame_count;
  logic [rpf_pkg::NUM_CH-1:0]              pin_on;

  rpf_pkg::slot_t                          pwm_tick_next;
  rpf_pkg::level_t [rpf_pkg::NUM_CH-1:0]   levels_next;
  rpf_pkg::level_t [rpf_pkg::NUM_CH-1:0]   targets_next;
  logic                                    fading_next;
  logic [7:0]                              frame_count_next;
  logic [rpf_pkg::NUM_CH-1:0]              pin_on_next;

  rpf_pkg::level_t [rpf_pkg::NUM_CH-1:0]   color;
  logic [7:0]                              frame_inc;
  logic [7:0]                              slot_scaled;
  logic                                    fade_go;
  logic                                    moved;

  assign color = {item.blue, item.green, item.red};

  always_comb begin
    pwm_tick_next    = pwm_tick;
    levels_next      = levels;
    targets_next     = targets;
    fading_next      = fading;
    frame_count_next = frame_count;
    pin_on_next      = pin_on;
    frame_inc        = frame_count + 8'd1;
    fade_go          = 1'b0;
    moved            = 1'b0;
    slot_scaled      = '0;
    case (item.req_type)
      rpf_pkg::REQ_TICK: begin
        if (pwm_tick == rpf_pkg::LAST_SLOT) begin
          pwm_tick_next = '0;
          if (fading) begin
            frame_count_next = frame_inc;
            if (frame_inc >= frames_per_step) begin
              frame_count_next = '0;
              fade_go          = 1'b1;
            end
          end
        end else begin
          pwm_tick_next = pwm_tick + 6'd1;
        end
        // Move each channel one unit toward its target
        if (fade_go) begin
          for (int c = 0; c < rpf_pkg::NUM_CH; c++) begin
            if (targets[c] > levels[c]) begin
              levels_next[c] = levels[c] + 8'd1;
              moved          = 1'b1;
            end else if (targets[c] < levels[c]) begin
              levels_next[c] = levels[c] - 8'd1;
              moved          = 1'b1;
            end
          end
          if (!moved) begin
            fading_next = 1'b0;
          end
        end
        slot_scaled = {pwm_tick_next, 2'b00};
        for (int c = 0; c < rpf_pkg::NUM_CH; c++) begin
          if (pwm_tick_next == '0) begin
            if (levels_next[c] != '0) begin
              pin_on_next[c] = 1'b1;
            end
          end else if (slot_scaled >= levels_next[c]) begin
            pin_on_next[c] = 1'b0;
          end
        end
      end
      rpf_pkg::REQ_SET: begin
        levels_next   = color;
        targets_next  = color;
        fading_next   = 1'b0;
        pwm_tick_next = '0;
      end
      rpf_pkg::REQ_FADE: begin
        targets_next = color;
        fading_next  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_step <= rpf_pkg::FPS_RESET;
    end else if (cfg_we) begin
      frames_per_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_tick    <= '0;
      levels      <= '0;
      targets     <= '0;
      fading      <= 1'b0;
      frame_count <= '0;
      pin_on      <= '0;
    end else if (step) begin
      pwm_tick    <= pwm_tick_next;
      levels      <= levels_next;
      targets     <= targets_next;
      fading      <= fading_next;
      frame_count <= frame_count_next;
      pin_on      <= pin_on_next;
    end
  end

  always_comb begin
    result.red_on      = pin_on_next[0];
    result.green_on    = pin_on_next[1];
    result.blue_on     = pin_on_next[2];
    result.fading_now  = fading_next;
    result.level_red   = levels_next[0];
    result.level_green = levels_next[1];
    result.level_blue  = levels_next[2];
  end

`ifndef NO_ASSERTIONS
  a_fade_starts: assert property (@(posedge clk) disable iff (rst)
    (step && item.req_type == rpf_pkg::REQ_FADE) |=> fading)
    else $error("fade request did not start the fade");

  a_set_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && item.req_type == rpf_pkg::REQ_SET) |=> (pwm_tick == '0 && !fading))
    else $error("set request did not restart the period");

  a_pin_on_slot0: assert property (@(posedge clk) disable iff (rst)
    ($rose(pin_on[0]) || $rose(pin_on[1]) || $rose(pin_on[2])) |-> pwm_tick == '0)
    else $error("channel switched on outside slot 0");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !fading |=> ($stable(levels) || $past(step && item.req_type == rpf_pkg::REQ_SET)))
    else $error("level moved without a fade or set");
`endif

endmodule

// File: src/rgb_pwm_fade_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pwm_fade_controller
// Three-channel LED PWM with a 64-slot period and a linear fade engine.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one result beat carrying the channel drive,
// the fade flag and the three channel levels as they stand after the request.
// A tick (req_type 0) advances the 64-slot period; a set (1) loads levels and
// targets at once, stops any fade and restarts the period; a fade (2) loads
// the targets and starts stepping the levels one unit every frames_per_step
// periods. The block takes one beat every clock cycle unless the result side
// stalls; a beat passes the request register, then the result register, with
// all state update and drive compare in the single logic level between them.
// Write frames_per_step through cfg_we/cfg_wdata only while no beat is in
// flight.
module rgb_pwm_fade_controller (
  input  logic              clk,
  input  logic              rst,
  rpf_req_if.sink           req,
  rpf_res_if.source         res,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  // Request register
  logic             s1_valid;
  rpf_pkg::req_t    s1_item;

  // Result register
  logic             res_valid;
  rpf_pkg::result_t res_data;

  rpf_pkg::result_t core_result;
  logic             advance;
  logic             step;

  // Advance whenever the result register is empty or being drained
  assign advance   = !res_valid || res.ready;
  assign step      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // Capture the request beat payload
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_item.req_type <= rpf_pkg::req_e'(req.req_type);
      s1_item.red      <= req.red;
      s1_item.green    <= req.green;
      s1_item.blue     <= req.blue;
    end
  end

  rpf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (s1_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= core_result;
    end
  end

  assign res.valid       = res_valid;
  assign res.red_on      = res_data.red_on;
  assign res.green_on    = res_data.green_on;
  assign res.blue_on     = res_data.blue_on;
  assign res.fading_now  = res_data.fading_now;
  assign res.level_red   = res_data.level_red;
  assign res.level_green = res_data.level_green;
  assign res.level_blue  = res_data.level_blue;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB PWM fade controller.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver on the request channel.
// Every accepted beat runs through a local model of the PWM slot counter,
// the fade engine and the channel drive. The model's answer is queued as the
// expected result. A clocked monitor on the result channel checks each
// result beat, field by field, against the oldest expected result.
// The run opens with a short directed sequence. Several random phases follow,
// each with its own frames_per_step setting; the register is written only
// while nothing is in flight. Both sides idle in random bursts. The receiver
// also stalls once for a long stretch, which fills the block and pushes back
// on its input. The last phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
  localparam int LONG_STALL  = 300;   // receiver hold-off, in cycles
  localparam int STALL_AFTER = 300;   // result beats seen before that hold-off

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  rpf_req_if req_ch ();
  rpf_res_if res_ch ();

  rgb_pwm_fade_controller dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local model of the controller state
  // --------------------------------------------------------------------------
  logic [7:0]      ps_fps    = rpf_pkg::FPS_RESET;
  rpf_pkg::slot_t  ps_slot   = '0;
  rpf_pkg::level_t ps_level  [rpf_pkg::NUM_CH] = '{default: '0};
  rpf_pkg::level_t ps_target [rpf_pkg::NUM_CH] = '{default: '0};
  logic            ps_fading = 1'b0;
  logic [7:0]      ps_frames = '0;
  logic            ps_drive  [rpf_pkg::NUM_CH] = '{default: 1'b0};

  int fades_done = 0;

  // Apply one request beat to the model and return the result it should show.
  function automatic rpf_pkg::result_t apply_request(rpf_pkg::req_t r);
    rpf_pkg::level_t  col [rpf_pkg::NUM_CH];
    logic [9:0]       slot_x4;
    logic             moved;
    int               c;
    rpf_pkg::result_t o;
    col[0] = r.red;
    col[1] = r.green;
    col[2] = r.blue;
    case (r.req_type)
      rpf_pkg::REQ_TICK: begin
        if (ps_slot >= rpf_pkg::LAST_SLOT) begin
          // Period wraps: count a frame only while a fade runs.
          ps_slot = '0;
          if (ps_fading) begin
            ps_frames = ps_frames + 8'd1;
            // Compare with >= so a zero or freshly lowered setting steps now.
            if (ps_frames >= ps_fps) begin
              ps_frames = '0;
              moved = 1'b0;
              for (c = 0; c < rpf_pkg::NUM_CH; c++) begin
                if (ps_target[c] > ps_level[c]) begin
                  ps_level[c] = ps_level[c] + 8'd1;
                  moved = 1'b1;
                end else if (ps_target[c] < ps_level[c]) begin
                  ps_level[c] = ps_level[c] - 8'd1;
                  moved = 1'b1;
                end
              end
              // Nothing left to move: the fade is over.
              if (!moved) begin
                ps_fading = 1'b0;
                fades_done++;
              end
            end
          end
        end else begin
          ps_slot = ps_slot + 6'd1;
        end
        if (ps_slot == '0) begin
          // Slot zero: switch on every lit channel, leave dark ones as they are.
          for (c = 0; c < rpf_pkg::NUM_CH; c++)
            if (ps_level[c] != '0) ps_drive[c] = 1'b1;
        end else begin
          // Later slots: switch off once four times the slot reaches the level.
          slot_x4 = 10'(ps_slot) * 10'd4;
          for (c = 0; c < rpf_pkg::NUM_CH; c++)
            if (slot_x4 >= 10'(ps_level[c])) ps_drive[c] = 1'b0;
        end
      end
      rpf_pkg::REQ_SET: begin
        // Load at once and restart the period; drive waits for the next tick.
        for (c = 0; c < rpf_pkg::NUM_CH; c++) begin
          ps_level[c]  = col[c];
          ps_target[c] = col[c];
        end
        ps_fading = 1'b0;
        ps_slot   = '0;
      end
      rpf_pkg::REQ_FADE: begin
        for (c = 0; c < rpf_pkg::NUM_CH; c++) ps_target[c] = col[c];
        ps_fading = 1'b1;
      end
      default: begin
      end
    endcase
    o.red_on      = ps_drive[0];
    o.green_on    = ps_drive[1];
    o.blue_on     = ps_drive[2];
    o.fading_now  = ps_fading;
    o.level_red   = ps_level[0];
    o.level_green = ps_level[1];
    o.level_blue  = ps_level[2];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  rpf_pkg::req_t    pending_q [$];
  rpf_pkg::result_t expected_q [$];
  rpf_pkg::req_t    on_wire;
  bit               idle_on = 1'b1;
  int               src_wait = 0;
  int               beats_in = 0;
  int               req_count [4] = '{default: 0};

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      // Predict the beat that just went in.
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(apply_request(on_wire));
        req_count[on_wire.req_type]++;
        beats_in++;
      end
      // Advance to the next beat only when the current one is gone.
      if (!req_ch.valid || req_ch.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          on_wire = pending_q.pop_front();
          req_ch.req_type <= on_wire.req_type;
          req_ch.red      <= on_wire.red;
          req_ch.green    <= on_wire.green;
          req_ch.blue     <= on_wire.blue;
          req_ch.valid    <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) src_wait = $urandom_range(1, 11);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  rpf_pkg::result_t seen_beat;
  rpf_pkg::result_t want_beat;
  int               beats_out = 0;
  int               mismatches = 0;
  int               sink_wait = 0;
  bit               long_stall_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        seen_beat.red_on      = res_ch.red_on;
        seen_beat.green_on    = res_ch.green_on;
        seen_beat.blue_on     = res_ch.blue_on;
        seen_beat.fading_now  = res_ch.fading_now;
        seen_beat.level_red   = res_ch.level_red;
        seen_beat.level_green = res_ch.level_green;
        seen_beat.level_blue  = res_ch.level_blue;
        beats_out++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat %0d arrived with nothing expected", $time, beats_out);
        end else begin
          want_beat = expected_q.pop_front();
          if (seen_beat.red_on      !== want_beat.red_on      ||
              seen_beat.green_on    !== want_beat.green_on    ||
              seen_beat.blue_on     !== want_beat.blue_on     ||
              seen_beat.fading_now  !== want_beat.fading_now  ||
              seen_beat.level_red   !== want_beat.level_red   ||
              seen_beat.level_green !== want_beat.level_green ||
              seen_beat.level_blue  !== want_beat.level_blue) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: beat %0d mismatch: expected on=%b%b%b fade=%b lvl=%0d/%0d/%0d",
                       $time, beats_out,
                       want_beat.red_on, want_beat.green_on, want_beat.blue_on,
                       want_beat.fading_now, want_beat.level_red, want_beat.level_green,
                       want_beat.level_blue);
              $display("    got on=%b%b%b fade=%b lvl=%0d/%0d/%0d",
                       seen_beat.red_on, seen_beat.green_on,
                       seen_beat.blue_on, seen_beat.fading_now, seen_beat.level_red,
                       seen_beat.level_green, seen_beat.level_blue);
            end
          end
        end
      end
      // Hold off once for a long stretch so the block backs up into its input.
      if (!long_stall_done && beats_out >= STALL_AFTER) begin
        long_stall_done = 1'b1;
        sink_wait = LONG_STALL;
        res_ch.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_wait = $urandom_range(0, 10);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither side moves a beat for too long
  // --------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL rgb_pwm_fade_controller");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Where the generator thinks levels head
  rpf_pkg::level_t aim [rpf_pkg::NUM_CH] = '{default: '0};
  int              settings_used = 1;

  task automatic add_req(rpf_pkg::req_e t, rpf_pkg::level_t r, rpf_pkg::level_t g,
                         rpf_pkg::level_t b);
    rpf_pkg::req_t q;
    q.req_type = t;
    q.red      = r;
    q.green    = g;
    q.blue     = b;
    pending_q.push_back(q);
  endtask

  // Mix of dark, dim, never-off and arbitrary levels.
  function automatic rpf_pkg::level_t pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return rpf_pkg::level_t'($urandom_range(252, 255));
      3:       return rpf_pkg::level_t'($urandom_range(1, 4));
      default: return rpf_pkg::level_t'($urandom);
    endcase
  endfunction

  // Target a few units from the current aim so fades can finish in a phase.
  function automatic rpf_pkg::level_t near_level(rpf_pkg::level_t v);
    int t;
    t = int'(v) + int'($urandom_range(0, 4)) - 2;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return rpf_pkg::level_t'(t);
  endfunction

  task automatic random_phase(int budget);
    int made;
    int pick;
    int run;
    int c;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        for (c = 0; c < rpf_pkg::NUM_CH; c++) aim[c] = pick_level();
        add_req(rpf_pkg::REQ_SET, aim[0], aim[1], aim[2]);
      end else if (pick < 60) begin
        for (c = 0; c < rpf_pkg::NUM_CH; c++) aim[c] = near_level(aim[c]);
        add_req(rpf_pkg::REQ_FADE, aim[0], aim[1], aim[2]);
      end else if (pick < 66) begin
        // Far fade: keeps the engine busy until a set cuts it short.
        for (c = 0; c < rpf_pkg::NUM_CH; c++) aim[c] = rpf_pkg::level_t'($urandom);
        add_req(rpf_pkg::REQ_FADE, aim[0], aim[1], aim[2]);
      end else if (pick < 71) begin
        add_req(rpf_pkg::REQ_NONE, rpf_pkg::level_t'($urandom),
                rpf_pkg::level_t'($urandom), rpf_pkg::level_t'($urandom));
      end
      if (pick < 71) made++;
      // Short runs poke inside a period, long runs span wraps and fade steps.
      run = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(64, 160);
      // Stay within the phase budget.
      if (run > budget - made) run = budget - made;
      repeat (run)
        add_req(rpf_pkg::REQ_TICK, rpf_pkg::level_t'($urandom),
                rpf_pkg::level_t'($urandom), rpf_pkg::level_t'($urandom));
      made += run;
    end
  endtask

  // Wait until the driver is empty and every expected result has come back.
  // Check between edges so the driver's updates have all settled.
  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || req_ch.valid)
      @(negedge clk);
  endtask

  task automatic write_fps(logic [7:0] v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    ps_fps     = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = rpf_pkg::REQ_TICK;
    req_ch.red       = '0;
    req_ch.green     = '0;
    req_ch.blue      = '0;
    res_ch.ready     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unused code, extremes, never-off levels, dark channels.
    add_req(rpf_pkg::REQ_NONE, 8'hA5, 8'h5A, 8'hFF);
    add_req(rpf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    add_req(rpf_pkg::REQ_SET,  8'd255, 8'd253, 8'd252);  // drive must not move on a set
    add_req(rpf_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF);
    add_req(rpf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    add_req(rpf_pkg::REQ_SET,  8'd0, 8'd1, 8'd4);
    add_req(rpf_pkg::REQ_TICK, 8'h12, 8'h34, 8'h56);
    add_req(rpf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    add_req(rpf_pkg::REQ_FADE, 8'd255, 8'd0, 8'd128);
    add_req(rpf_pkg::REQ_NONE, 8'd0, 8'd0, 8'd0);
    add_req(rpf_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    add_req(rpf_pkg::REQ_SET,  8'd255, 8'd255, 8'd255);
    add_req(rpf_pkg::REQ_FADE, 8'd0, 8'd0, 8'd0);
    add_req(rpf_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    add_req(rpf_pkg::REQ_SET,  8'd128, 8'd64, 8'd0);
    add_req(rpf_pkg::REQ_FADE, 8'd128, 8'd64, 8'd0);     // fade to where it already is
    add_req(rpf_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0);
    aim = '{8'd128, 8'd64, 8'd0};

    // Random phases; each boundary pauses the sender until all results are in.
    random_phase(350);
    write_fps(8'd255);
    random_phase(100);
    write_fps(8'd0);
    random_phase(120);
    write_fps(8'd2);
    random_phase(250);
    idle_on = 1'b0;
    write_fps(8'd1);
    random_phase(180);

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d request beats (%0d ticks, %0d sets, %0d fades, %0d unused)",
             beats_in, req_count[rpf_pkg::REQ_TICK], req_count[rpf_pkg::REQ_SET],
             req_count[rpf_pkg::REQ_FADE], req_count[rpf_pkg::REQ_NONE]);
    $display("over %0d step settings, %0d fades run to the end, %0d mismatches",
             settings_used, fades_done, mismatches);
    if (mismatches == 0)
      $display("PASS rgb_pwm_fade_controller");
    else
      $display("FAIL rgb_pwm_fade_controller");
    $finish;
  end

endmodule
